// ===== rtl/aimd_pkg.sv =====
// Shared types, codes and helper functions for the AIMD backoff delay controller.
package aimd_pkg;

    localparam int DELAY_W    = 20;
    localparam int COUNT_W    = 16;
    localparam int KIND_W     = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MIN_DELAY       = 3'd0,
        CFG_MAX_DELAY       = 3'd1,
        CFG_SWITCH_LEVEL    = 3'd2,
        CFG_ADD_STEP        = 3'd3,
        CFG_DIVISOR         = 3'd4,
        CFG_LONG_WAIT_LIMIT = 3'd5
    } cfg_idx_t;

    typedef enum logic [KIND_W-1:0] {
        REQ_INC  = 2'd0,
        REQ_DEC  = 2'd1,
        REQ_WAIT = 2'd2,
        REQ_SET  = 2'd3
    } req_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_COMMIT,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic load_req;
        logic eval;
        logic div_step;
        logic div_commit;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [DELAY_W-1:0] eff_min(
        input logic [DELAY_W-1:0] mn,
        input logic [DELAY_W-1:0] ceil
    );
        logic [DELAY_W-1:0] m;
        m = mn;
        if (m == '0) m = DELAY_W'(1);
        if (m > ceil) m = ceil;
        return m;
    endfunction

    function automatic logic [DELAY_W-1:0] eff_max(
        input logic [DELAY_W-1:0] mn,
        input logic [DELAY_W-1:0] mx,
        input logic [DELAY_W-1:0] ceil
    );
        logic [DELAY_W-1:0] lo;
        logic [DELAY_W-1:0] m;
        lo = eff_min(mn, ceil);
        m  = mx;
        if (m > ceil) m = ceil;
        if (m < lo) m = lo;
        return m;
    endfunction

    function automatic logic [DELAY_W-1:0] eff_switch(
        input logic [DELAY_W-1:0] mn,
        input logic [DELAY_W-1:0] mx,
        input logic [DELAY_W-1:0] sw,
        input logic [DELAY_W-1:0] ceil
    );
        logic [DELAY_W-1:0] lo;
        logic [DELAY_W-1:0] hi;
        lo = eff_min(mn, ceil);
        hi = eff_max(mn, mx, ceil);
        if (sw >= lo && sw <= hi) return sw;
        return lo;
    endfunction

endpackage

// ===== rtl/aimd_ctrl.sv =====
// Control state machine: sequences accept, evaluate, divide and result hand-off.
module aimd_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  aimd_pkg::dp_status_t   status,
    output aimd_pkg::ctrl_cmd_t    cmd
);
    import aimd_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = status.need_div ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                cmd.div_commit = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/aimd_dp.sv =====
// Datapath: config registers, delay/count state, restoring divider, output register.
module aimd_dp #(
    parameter int DELAY_CEILING = 999999
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [aimd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [aimd_pkg::DELAY_W-1:0]        cfg_wdata,
    input  logic [aimd_pkg::KIND_W-1:0]         req_kind,
    input  logic [aimd_pkg::DELAY_W-1:0]        req_delay,
    input  aimd_pkg::ctrl_cmd_t                 cmd,
    output aimd_pkg::dp_status_t                status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [aimd_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import aimd_pkg::*;

    localparam logic [DELAY_W-1:0] CEIL     = DELAY_W'(DELAY_CEILING);
    localparam int                 DIV_CW   = $clog2(DELAY_W);
    localparam int                 PAD_W    = OUT_DATA_W - DELAY_W - COUNT_W - 1;

    logic [DELAY_W-1:0] min_reg, max_reg, switch_reg, step_reg, divisor_reg;
    logic [COUNT_W-1:0] limit_reg;
    logic [DELAY_W-1:0] min_next, max_next, switch_next, step_next, divisor_next;
    logic [COUNT_W-1:0] limit_next;

    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [DELAY_W-1:0] req_reg, req_next;

    logic [DELAY_W-1:0] quo_reg, quo_next;
    logic [DELAY_W-1:0] rem_reg, rem_next;
    logic [DELAY_W-1:0] dvs_reg, dvs_next;
    logic [DIV_CW-1:0]  cnt_reg, cnt_next;

    logic               out_valid_reg, out_valid_next;
    logic [DELAY_W-1:0] out_delay_reg, out_delay_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_lim_reg, out_lim_next;

    logic [DELAY_W-1:0] lo, hi, sw, step_eff, dvs_eff;
    logic [COUNT_W-1:0] lim;
    logic [DELAY_W:0]   grow;
    logic [DELAY_W-1:0] inc_val;
    logic [DELAY_W:0]   rem_sh;
    logic [DELAY_W:0]   rem_sub;
    logic               rem_ge;
    logic [DELAY_W-1:0] old_hi, new_hi;

    assign lo       = eff_min(min_reg, CEIL);
    assign hi       = eff_max(min_reg, max_reg, CEIL);
    assign sw       = eff_switch(min_reg, max_reg, switch_reg, CEIL);
    assign step_eff = (step_reg == '0) ? DELAY_W'(1) : step_reg;
    assign dvs_eff  = (divisor_reg < DELAY_W'(2)) ? DELAY_W'(2) : divisor_reg;
    assign lim      = (limit_reg == '0) ? COUNT_W'(1) : limit_reg;

    assign grow    = (delay_reg >= sw) ? ({1'b0, delay_reg} + {1'b0, step_eff})
                                       : {delay_reg, 1'b0};
    assign inc_val = (grow < {1'b0, hi}) ? grow[DELAY_W-1:0] : hi;

    assign rem_sh  = {rem_reg, quo_reg[DELAY_W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign rem_ge  = rem_sh >= {1'b0, dvs_reg};

    assign old_hi = hi;

    assign status.need_div = (req_kind_t'(kind_reg) == REQ_DEC) && (delay_reg > lo);
    assign status.div_last = (cnt_reg == DIV_CW'(DELAY_W - 1));
    assign status.out_free = !out_valid_reg || m_tready;

    always_comb begin
        min_next     = min_reg;
        max_next     = max_reg;
        switch_next  = switch_reg;
        step_next    = step_reg;
        divisor_next = divisor_reg;
        limit_next   = limit_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_MIN_DELAY:       min_next     = cfg_wdata;
                CFG_MAX_DELAY:       max_next     = cfg_wdata;
                CFG_SWITCH_LEVEL:    switch_next  = cfg_wdata;
                CFG_ADD_STEP:        step_next    = cfg_wdata;
                CFG_DIVISOR:         divisor_next = cfg_wdata;
                CFG_LONG_WAIT_LIMIT: limit_next   = cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign new_hi = eff_max(min_next, max_next, CEIL);

    always_comb begin
        delay_next     = delay_reg;
        count_next     = count_reg;
        kind_next      = kind_reg;
        req_next       = req_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_delay_next = out_delay_reg;
        out_count_next = out_count_reg;
        out_lim_next   = out_lim_reg;

        if (cmd.load_req) begin
            kind_next = req_kind;
            req_next  = req_delay;
        end

        if (cmd.eval) begin
            case (req_kind_t'(kind_reg))
                REQ_INC: begin
                    if (delay_reg < hi) delay_next = inc_val;
                end
                REQ_DEC: begin
                    count_next = '0;
                    quo_next   = delay_reg;
                    rem_next   = '0;
                    dvs_next   = dvs_eff;
                    cnt_next   = '0;
                end
                REQ_WAIT: begin
                    if (delay_reg >= hi && count_reg < lim) count_next = count_reg + COUNT_W'(1);
                end
                REQ_SET: begin
                    if (req_reg >= lo && req_reg <= hi) delay_next = req_reg;
                end
                default: ;
            endcase
        end

        if (cmd.div_step) begin
            rem_next = rem_ge ? rem_sub[DELAY_W-1:0] : rem_sh[DELAY_W-1:0];
            quo_next = {quo_reg[DELAY_W-2:0], rem_ge};
            cnt_next = cnt_reg + DIV_CW'(1);
        end

        if (cmd.div_commit) begin
            delay_next = (quo_reg > lo) ? quo_reg : lo;
        end

        if (m_tready) out_valid_next = 1'b0;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
            out_delay_next = delay_reg;
            out_count_next = count_reg;
            out_lim_next   = (count_reg >= lim);
        end

        if (cfg_wr_en && new_hi > old_hi) count_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg       <= DELAY_W'(1);
            max_reg       <= DELAY_W'(1024);
            switch_reg    <= DELAY_W'(64);
            step_reg      <= DELAY_W'(1);
            divisor_reg   <= DELAY_W'(2);
            limit_reg     <= COUNT_W'(1);
            delay_reg     <= DELAY_W'(1);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            min_reg       <= min_next;
            max_reg       <= max_next;
            switch_reg    <= switch_next;
            step_reg      <= step_next;
            divisor_reg   <= divisor_next;
            limit_reg     <= limit_next;
            delay_reg     <= delay_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        req_reg       <= req_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        dvs_reg       <= dvs_next;
        cnt_reg       <= cnt_next;
        out_delay_reg <= out_delay_next;
        out_count_reg <= out_count_next;
        out_lim_reg   <= out_lim_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_lim_reg, out_count_reg, out_delay_reg};

`ifndef NO_ASSERTIONS
    a_delay_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        delay_reg != '0)
        else $error("delay state reached zero");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over an untaken beat");

    a_commit_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_commit |-> $past(cmd.div_step) && $past(status.div_last))
        else $error("quotient committed before divider finished");
`endif

endmodule

// ===== rtl/aimd_backoff_delay_controller_top.sv =====
// AIMD backoff delay controller: event in, delay and long-wait count out.
//
// Input beat (s_*): s_tuser[1:0] = event kind (increase, decrease, wait, set),
// s_tdata[19:0] = delay requested by a set event. One result beat per event.
// Result beat (m_*): m_tdata holds delay_now, long_waits and limit_reached.
// Config: cfg_wr_en/cfg_addr/cfg_wdata write one register per cycle; the user must write only
// while idle, which the block itself does not enforce. Steps: accept, evaluate, then output
// for increase, wait and set; a decrease that divides runs 20 restoring-divider steps
// and a commit between evaluate and output. A new event is accepted only after the last
// one's result is loaded, with one shared bit-serial divider and a one-event-at-a-time sequencer.
// The result sits in an output register: a new event is accepted while it waits,
// but the next result holds in the sequencer until the receiver takes the beat.
// Reset (aresetn low, synchronous) restores register defaults, delay = 1,
// long-wait count = 0, and empties the output register.
module aimd_backoff_delay_controller_top #(
    parameter int DELAY_CEILING = 999999
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [aimd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [aimd_pkg::DELAY_W-1:0]        cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [aimd_pkg::IN_DATA_W-1:0]      s_tdata,   // [19:0] new_delay
    input  logic [aimd_pkg::KIND_W-1:0]         s_tuser,   // [1:0] req_type
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [aimd_pkg::OUT_DATA_W-1:0]     m_tdata    // [19:0] delay_now,
                                                           // [35:20] long_waits,
                                                           // [36] limit_reached
);
    import aimd_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    aimd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    aimd_dp #(
        .DELAY_CEILING (DELAY_CEILING)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .req_kind  (s_tuser),
        .req_delay (s_tdata[DELAY_W-1:0]),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
